[hw/rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 8;
	localparam int COL_IN_W = 7;
	localparam int ROW_IN_W = 5;
	localparam int CURSOR_W = 11;
	localparam int CELL_W   = CHAR_W + COLOR_W;

	localparam logic [CHAR_W-1:0]  SPACE_CHAR   = 8'd32;
	localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'd10;
	localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd7;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic REG_TEXT_COLOR = 1'b0;
	localparam logic REG_FILL_COLOR = 1'b1;

	typedef enum logic [1:0] {
		REQ_PRINT = 2'd0,
		REQ_PUT   = 2'd1,
		REQ_READ  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EMIT,
		ST_PRIME,
		ST_SCROLL,
		ST_PUT,
		ST_READ,
		ST_READ_WAIT,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

[hw/rtl/text_console_writer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: a grid of character and color cells with a cursor.
// ----------------------------------------------------------------------------
// The screen lives in one single-port-write, single-port-read memory that a
// small sequencer walks one cell per cycle, and the block takes one request at
// a time. After reset the block fills the screen with spaces before it takes
// its first request; register writes are taken during that time. A printed
// character passes through ST_EMIT and a put through ST_PUT, a read through
// ST_READ and ST_READ_WAIT, and each then through ST_DONE, where the result is
// registered. A newline writes one cell per cycle up to the next row boundary.
// A scroll copies the whole screen up one row and fills the bottom row, and a
// clear rewrites every cell; both are bounded by the one write port of the
// screen memory. A result that is still held at the output stalls the block
// in ST_DONE, so the next request waits.
// ----------------------------------------------------------------------------
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,

	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [1:0]            req_type,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [COLOR_W-1:0]    cell_color,
	input  logic [COL_IN_W-1:0]   column,
	input  logic [ROW_IN_W-1:0]   row,

	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic [CHAR_W-1:0]     read_char,
	output logic [COLOR_W-1:0]    read_color,
	output logic [CURSOR_W-1:0]   cursor_cell,
	output logic                  scrolled
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);

	state_t state_q, state_d;

	logic [COLOR_W-1:0] text_color_q, fill_color_q;
	logic [AW-1:0]      cursor_q;
	logic [CW-1:0]      col_q;
	logic [AW-1:0]      idx_q;
	logic               scr_q;
	logic               rsp_valid_q;

	logic [CHAR_W-1:0]  ch_q;
	logic [COLOR_W-1:0] color_q;
	logic               nl_q;
	logic [AW-1:0]      pos_q;
	logic               in_range_q;
	logic [CELL_W-1:0]  rdata_q;
	logic [CHAR_W-1:0]  rd_char_q;
	logic [COLOR_W-1:0] rd_color_q;

	logic [CHAR_W-1:0]   read_char_q;
	logic [COLOR_W-1:0]  read_color_q;
	logic [CURSOR_W-1:0] cursor_cell_q;
	logic                scrolled_q;

	logic [CELL_W-1:0] mem [CELLS];

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata;

	logic          accept, cfg_write, rsp_load;
	logic          idx_last, cursor_last, idx_in_body;
	logic [CW-1:0] col_next;
	logic [31:0]   pos_full, cursor_wide, scroll_rd_full;
	logic          pos_ok, scroll_rd_ok;
	req_t          req_in;

	assign req_in    = req_t'(req_type);
	assign accept    = req_valid && req_ready;
	assign cfg_write = psel && penable && pwrite && pready;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	assign idx_last    = (idx_q == AW'(CELLS - 1));
	assign cursor_last = (cursor_q == AW'(CELLS - 1));
	assign idx_in_body = (32'(idx_q) < 32'(CELLS - COLUMNS));
	assign col_next    = (col_q == CW'(COLUMNS - 1)) ? '0 : col_q + 1'b1;

	assign pos_full = 32'(row) * 32'(COLUMNS) + 32'(column);
	assign pos_ok   = (32'(column) < 32'(COLUMNS)) && (32'(row) < 32'(ROWS));

	assign scroll_rd_full = 32'(idx_q) + 32'(COLUMNS + 1);
	assign scroll_rd_ok   = (scroll_rd_full < 32'(CELLS));
	assign cursor_wide    = 32'(cursor_q);

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FILL_COLOR) ? APB_DATA_W'(fill_color_q)
	                                             : APB_DATA_W'(text_color_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= COLOR_RESET;
			fill_color_q <= COLOR_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == REG_TEXT_COLOR) begin
				text_color_q <= pwdata[COLOR_W-1:0];
			end else begin
				fill_color_q <= pwdata[COLOR_W-1:0];
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (idx_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					case (req_in)
						REQ_PRINT: state_d = ST_EMIT;
						REQ_PUT:   state_d = ST_PUT;
						REQ_READ:  state_d = ST_READ;
						REQ_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_EMIT: begin
				if (cursor_last) begin
					state_d = ST_PRIME;
				end else if (nl_q && (col_next != '0)) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PRIME:     state_d = ST_SCROLL;
			ST_SCROLL: begin
				if (idx_last) state_d = ST_DONE;
			end
			ST_PUT:       state_d = ST_DONE;
			ST_READ:      state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_DONE;
			ST_CLEAR: begin
				if (idx_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// Memory control and handshake outputs.
	always_comb begin
		req_ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = {fill_color_q, SPACE_CHAR};
		mem_re    = 1'b0;
		mem_raddr = pos_q;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {COLOR_RESET, SPACE_CHAR};
			end
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_EMIT: begin
				mem_we    = 1'b1;
				mem_waddr = cursor_q;
				mem_wdata = {text_color_q, ch_q};
			end
			ST_PRIME: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(COLUMNS);
			end
			ST_SCROLL: begin
				mem_we    = 1'b1;
				mem_wdata = idx_in_body ? rdata_q : {fill_color_q, SPACE_CHAR};
				mem_re    = scroll_rd_ok;
				mem_raddr = scroll_rd_full[AW-1:0];
			end
			ST_PUT: begin
				mem_we    = in_range_q;
				mem_waddr = pos_q;
				mem_wdata = {color_q, ch_q};
			end
			ST_READ: begin
				mem_re = in_range_q;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = idx_in_body ? {text_color_q, SPACE_CHAR}
				                        : {fill_color_q, SPACE_CHAR};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Screen memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// Sequencer and cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cursor_q    <= '0;
			col_q       <= '0;
			idx_q       <= '0;
			scr_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_INIT, ST_SCROLL: begin
					idx_q <= idx_last ? '0 : idx_q + 1'b1;
				end
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						scr_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (cursor_last) begin
						cursor_q <= AW'(CELLS - COLUMNS);
						col_q    <= '0;
						idx_q    <= '0;
						scr_q    <= 1'b1;
					end else begin
						cursor_q <= cursor_q + 1'b1;
						col_q    <= col_next;
					end
				end
				ST_CLEAR: begin
					idx_q <= idx_last ? '0 : idx_q + 1'b1;
					if (idx_last) begin
						cursor_q <= '0;
						col_q    <= '0;
						scr_q    <= 1'b1;
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			nl_q       <= (req_in == REQ_PRINT) && (char_code == NEWLINE_CHAR);
			ch_q       <= ((req_in == REQ_PRINT) && (char_code == NEWLINE_CHAR))
			              ? SPACE_CHAR : char_code;
			color_q    <= cell_color;
			pos_q      <= pos_full[AW-1:0];
			in_range_q <= pos_ok;
			rd_char_q  <= '0;
			rd_color_q <= '0;
		end
		if (state_q == ST_READ_WAIT && in_range_q) begin
			rd_char_q  <= rdata_q[CHAR_W-1:0];
			rd_color_q <= rdata_q[CELL_W-1:CHAR_W];
		end
		if (rsp_load) begin
			read_char_q   <= rd_char_q;
			read_color_q  <= rd_color_q;
			cursor_cell_q <= cursor_wide[CURSOR_W-1:0];
			scrolled_q    <= scr_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign read_char   = read_char_q;
	assign read_color  = read_color_q;
	assign cursor_cell = cursor_cell_q;
	assign scrolled    = scrolled_q;

	// The cursor and its column counter always stay on the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cursor_q) < 32'(CELLS)) && (32'(col_q) < 32'(COLUMNS)))
		else $error("cursor left the screen");

	// The screen is never written while the block waits for a request.
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("screen written while idle");

	// A request is taken only one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second request taken while busy");

	// A result is loaded only after the previous one has been transferred.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(cursor_cell)))
		else $error("pending result overwritten");

endmodule

[tb/sv/text_console_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the register port and the request and result channels of the text console
// writer, keeps its own copy of the screen, cursor and colors, predicts the
// result of every request at its transfer and compares each result transfer
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module text_console_checker
	import tcw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	input  logic                  pready,

	input  logic                  req_valid,
	input  logic                  req_ready,
	input  logic [1:0]            req_type,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [COLOR_W-1:0]    cell_color,
	input  logic [COL_IN_W-1:0]   column,
	input  logic [ROW_IN_W-1:0]   row,

	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  logic [CHAR_W-1:0]     read_char,
	input  logic [COLOR_W-1:0]    read_color,
	input  logic [CURSOR_W-1:0]   cursor_cell,
	input  logic                  scrolled,

	output int                    fail_count,
	output int                    pending,
	output int                    checked_count,
	output int                    scroll_count,
	output int                    read_count
);

	localparam int CELLS    = COLUMNS_DEF * ROWS_DEF;
	localparam int LAST_ROW = CELLS - COLUMNS_DEF;

	typedef struct packed {
		logic [CHAR_W-1:0]   read_char;
		logic [COLOR_W-1:0]  read_color;
		logic [CURSOR_W-1:0] cursor_cell;
		logic                scrolled;
	} console_reply_t;

	logic [CELL_W-1:0]  screen [CELLS];
	int                 cursor_pos;
	logic [COLOR_W-1:0] text_color;
	logic [COLOR_W-1:0] fill_color;
	console_reply_t     expected_replies [$];

	function automatic logic [CELL_W-1:0] cell_value(logic [CHAR_W-1:0] ch,
			logic [COLOR_W-1:0] color);
		return {color, ch};
	endfunction

	function automatic void blank_cells(int first, int last, logic [COLOR_W-1:0] color);
		for (int i = first; i < last; i++)
			screen[i] = cell_value(SPACE_CHAR, color);
	endfunction

	// Writes one character at the cursor; returns 1 when the screen scrolled.
	function automatic bit emit_char(logic [CHAR_W-1:0] ch);
		screen[cursor_pos] = cell_value(ch, text_color);
		cursor_pos++;
		if (cursor_pos >= CELLS) begin
			for (int i = 0; i < LAST_ROW; i++)
				screen[i] = screen[i + COLUMNS_DEF];
			blank_cells(LAST_ROW, CELLS, fill_color);
			cursor_pos = LAST_ROW;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic console_reply_t console_step(req_t kind, logic [CHAR_W-1:0] ch,
			logic [COLOR_W-1:0] color, logic [COL_IN_W-1:0] x, logic [ROW_IN_W-1:0] y);
		console_reply_t reply;
		int             idx;
		bit             on_screen;
		reply     = '0;
		idx       = int'(y) * COLUMNS_DEF + int'(x);
		on_screen = (int'(x) < COLUMNS_DEF) && (int'(y) < ROWS_DEF);
		case (kind)
			REQ_PRINT: begin
				if (ch == NEWLINE_CHAR) begin
					// A newline at the start of a row still emits one space.
					if (cursor_pos % COLUMNS_DEF == 0)
						if (emit_char(SPACE_CHAR))
							reply.scrolled = 1'b1;
					while (cursor_pos % COLUMNS_DEF != 0)
						if (emit_char(SPACE_CHAR))
							reply.scrolled = 1'b1;
				end else begin
					reply.scrolled = emit_char(ch);
				end
			end
			REQ_PUT: begin
				if (on_screen)
					screen[idx] = cell_value(ch, color);
			end
			REQ_READ: begin
				if (on_screen)
					{reply.read_color, reply.read_char} = screen[idx];
			end
			REQ_CLEAR: begin
				blank_cells(0, LAST_ROW, text_color);
				blank_cells(LAST_ROW, CELLS, fill_color);
				cursor_pos     = 0;
				reply.scrolled = 1'b1;
			end
			default: begin
			end
		endcase
		reply.cursor_cell = CURSOR_W'(cursor_pos);
		return reply;
	endfunction

	function automatic void check_field(string name, logic [15:0] expected,
			logic [15:0] actual);
		if (actual !== expected) begin
			$error("%s: expected %0d, actual %0d", name, expected, actual);
			fail_count++;
		end
	endfunction

	initial begin
		fail_count    = 0;
		pending       = 0;
		checked_count = 0;
		scroll_count  = 0;
		read_count    = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		console_reply_t want;
		if (!arst_n) begin
			text_color = COLOR_RESET;
			fill_color = COLOR_RESET;
			blank_cells(0, CELLS, COLOR_RESET);
			cursor_pos = 0;
			expected_replies.delete();
			pending = 0;
		end else begin
			if (psel && penable && pready && pwrite) begin
				case (paddr[2])
					REG_TEXT_COLOR: text_color = pwdata[COLOR_W-1:0];
					REG_FILL_COLOR: fill_color = pwdata[COLOR_W-1:0];
					default: begin
					end
				endcase
			end
			if (psel && penable && pready && !pwrite)
				check_field("prdata",
					16'((paddr[2] == REG_FILL_COLOR) ? fill_color : text_color),
					16'(prdata[COLOR_W-1:0]));

			// A result transfer always belongs to an earlier request.
			if (rsp_valid && rsp_ready) begin
				if (expected_replies.size() == 0) begin
					$error("result transfer with no request outstanding");
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					check_field("read_char", 16'(want.read_char), 16'(read_char));
					check_field("read_color", 16'(want.read_color), 16'(read_color));
					check_field("cursor_cell", 16'(want.cursor_cell), 16'(cursor_cell));
					check_field("scrolled", 16'(want.scrolled), 16'(scrolled));
					checked_count++;
					if (want.scrolled)
						scroll_count++;
				end
			end

			if (req_valid && req_ready) begin
				expected_replies.push_back(console_step(req_t'(req_type), char_code, cell_color,
					column, row));
				if (req_t'(req_type) == REQ_READ)
					read_count++;
			end
			pending = expected_replies.size();
		end
	end

endmodule

[tb/sv/text_console_writer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// Drives the text console writer with a directed opening and then random
// text lines, newline runs, cell puts and reads, clears and noise, under
// several color settings and flow control patterns, including one long
// result hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module text_console_writer_unit_tb;
	import tcw_pkg::*;

	localparam int HOLD_CYCLES  = 3000;
	localparam int IDLE_LIMIT   = 25000;
	localparam int DRAIN_CYCLES = 50;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;

	logic                  psel       = 1'b0;
	logic                  penable    = 1'b0;
	logic                  pwrite     = 1'b0;
	logic [APB_ADDR_W-1:0] paddr      = '0;
	logic [APB_DATA_W-1:0] pwdata     = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	logic                  req_valid  = 1'b0;
	logic                  req_ready;
	logic [1:0]            req_type   = '0;
	logic [CHAR_W-1:0]     char_code  = '0;
	logic [COLOR_W-1:0]    cell_color = '0;
	logic [COL_IN_W-1:0]   column     = '0;
	logic [ROW_IN_W-1:0]   row        = '0;

	logic                  rsp_valid;
	logic                  rsp_ready  = 1'b0;
	logic [CHAR_W-1:0]     read_char;
	logic [COLOR_W-1:0]    read_color;
	logic [CURSOR_W-1:0]   cursor_cell;
	logic                  scrolled;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_active    = 1'b0;
	event hold_start;

	int sent_count   = 0;
	int quiet_cycles = 0;
	int fail_count;
	int pending;
	int checked_count;
	int scroll_count;
	int read_count;

	text_console_writer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.char_code  (char_code),
		.cell_color (cell_color),
		.column     (column),
		.row        (row),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.read_char  (read_char),
		.read_color (read_color),
		.cursor_cell(cursor_cell),
		.scrolled   (scrolled)
	);

	text_console_checker console_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.char_code    (char_code),
		.cell_color   (cell_color),
		.column       (column),
		.row          (row),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.read_char    (read_char),
		.read_color   (read_color),
		.cursor_cell  (cursor_cell),
		.scrolled     (scrolled),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked_count(checked_count),
		.scroll_count (scroll_count),
		.read_count   (read_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (hold_active)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always begin
		@(hold_start);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_item(req_t kind, logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] color,
			logic [COL_IN_W-1:0] x, logic [ROW_IN_W-1:0] y);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= kind;
		char_code  <= ch;
		cell_color <= color;
		column     <= x;
		row        <= y;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic print_byte(logic [CHAR_W-1:0] ch);
		send_item(REQ_PRINT, ch, COLOR_W'($urandom), COL_IN_W'($urandom), ROW_IN_W'($urandom));
	endtask

	task automatic apb_access(bit wr, logic idx, logic [COLOR_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_colors(logic [COLOR_W-1:0] text, logic [COLOR_W-1:0] fill);
		apb_access(1'b1, REG_TEXT_COLOR, text);
		apb_access(1'b1, REG_FILL_COLOR, fill);
		apb_access(1'b0, REG_TEXT_COLOR, '0);
		apb_access(1'b0, REG_FILL_COLOR, '0);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly text lines and newline runs, which walk the cursor down to the
	// bottom row and on into scrolling, mixed with puts, reads and clears.
	task automatic run_traffic(int count);
		int                  target;
		int                  pick;
		int                  len;
		logic [COL_IN_W-1:0] x;
		logic [ROW_IN_W-1:0] y;
		target = sent_count + count;
		while (sent_count < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 170) : $urandom_range(0, 30);
				repeat (len)
					print_byte(($urandom_range(0, 7) == 0) ? CHAR_W'($urandom_range(0, 255)) :
						CHAR_W'($urandom_range(32, 126)));
				if ($urandom_range(0, 4) != 0)
					print_byte(NEWLINE_CHAR);
			end else if (pick < 62) begin
				repeat ($urandom_range(1, 30)) print_byte(NEWLINE_CHAR);
			end else if (pick < 86) begin
				if ($urandom_range(0, 9) == 0) begin
					x = COL_IN_W'($urandom_range(0, 127));
					y = ROW_IN_W'($urandom_range(0, 31));
				end else begin
					x = COL_IN_W'($urandom_range(0, COLUMNS_DEF - 1));
					y = ROW_IN_W'($urandom_range(0, ROWS_DEF - 1));
				end
				send_item(REQ_PUT, CHAR_W'($urandom), COLOR_W'($urandom), x, y);
				if ($urandom_range(0, 9) < 7)
					send_item(REQ_READ, CHAR_W'($urandom), COLOR_W'($urandom), x, y);
				else
					send_item(REQ_READ, CHAR_W'($urandom), COLOR_W'($urandom),
						COL_IN_W'($urandom), ROW_IN_W'($urandom));
			end else if (pick < 90) begin
				send_item(REQ_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom),
					COL_IN_W'($urandom), ROW_IN_W'($urandom));
			end else begin
				send_item(req_t'($urandom_range(0, 3)), CHAR_W'($urandom), COLOR_W'($urandom),
					COL_IN_W'($urandom), ROW_IN_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		send_item(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0);
		print_byte(8'h41);
		print_byte(8'h00);
		print_byte(8'hFF);
		print_byte(NEWLINE_CHAR);
		print_byte(NEWLINE_CHAR);
		send_item(REQ_PUT, 8'hFF, 8'hFF, 7'd79, 5'd24);
		send_item(REQ_PUT, 8'h00, 8'h00, 7'd0, 5'd0);
		send_item(REQ_PUT, 8'h55, 8'hAA, 7'd127, 5'd0);
		send_item(REQ_PUT, 8'h55, 8'hAA, 7'd0, 5'd31);
		send_item(REQ_PUT, 8'h55, 8'hAA, 7'd80, 5'd25);
		send_item(REQ_PUT, 8'h55, 8'hAA, 7'd127, 5'd31);
		send_item(REQ_READ, 8'hFF, 8'hFF, 7'd79, 5'd24);
		send_item(REQ_READ, 8'hFF, 8'hFF, 7'd0, 5'd0);
		send_item(REQ_READ, 8'h00, 8'h00, 7'd1, 5'd0);
		send_item(REQ_READ, 8'h00, 8'h00, 7'd127, 5'd31);
		send_item(REQ_READ, 8'h00, 8'h00, 7'd80, 5'd0);
		send_item(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd25);
		send_item(REQ_READ, 8'h00, 8'h00, 7'd79, 5'd1);
		send_item(REQ_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31);
		send_item(REQ_READ, 8'h00, 8'h00, 7'd5, 5'd24);
		send_item(REQ_READ, 8'h00, 8'h00, 7'd5, 5'd0);
		print_byte(NEWLINE_CHAR);

		wait_idle();
		set_colors(8'h00, 8'hFF);
		run_traffic(300);

		wait_idle();
		set_colors(8'hFF, 8'h00);
		send_idle_pct = 81;
		run_traffic(300);

		wait_idle();
		set_colors(COLOR_W'($urandom), COLOR_W'($urandom));
		send_idle_pct  = 0;
		recv_stall_pct = 81;
		-> hold_start;
		run_traffic(300);

		wait_idle();
		set_colors(COLOR_W'($urandom), COLOR_W'($urandom));
		send_idle_pct  = 7;
		recv_stall_pct = 7;
		run_traffic(400);

		wait_idle();
		$display("Run covered %0d requests and %0d checked results, %0d reads and %0d scrolling,",
			sent_count, checked_count, read_count, scroll_count);
		$display("under five color settings with no stalls, heavy stalls and a long result hold-off.");
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
